### sv/marker_rle_block_decoder_unit_defines.svh
// Assertion macros used by the decoder top file, which carries the checks.
`ifndef MARKER_RLE_BLOCK_DECODER_UNIT_DEFINES_SVH
`define MARKER_RLE_BLOCK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MRLE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/mrle_pkg.sv
// ----------------------------------------------------------------------------
// mrle_pkg
// Shared types and constants of the marker byte run-length block decoder.
// ----------------------------------------------------------------------------
package mrle_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMED_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MARKER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd3;

	localparam logic [31:0] OUTPUT_LIMIT_RESET = 32'hffff_ffff;
	localparam logic [15:0] HEADER_BYTES = 16'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_value;
		logic [15:0] out_count;
		logic        clipped;
		logic        malformed;
		logic        stream_done;
	} result_t;

	typedef struct packed {
		logic        framed_mode;
		logic [7:0]  single_marker;
		logic        block_count_wr;
		logic        output_limit_wr;
		logic [31:0] wr_data;
	} cfg_t;

endpackage

### sv/mrle_if.sv
// ----------------------------------------------------------------------------
// mrle channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface mrle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mrle_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_value;
	logic [15:0] out_count;
	logic        clipped;
	logic        malformed;
	logic        stream_done;

	modport source (output valid, output out_value, output out_count, output clipped,
		output malformed, output stream_done, input ready);
	modport sink (input valid, input out_value, input out_count, input clipped,
		input malformed, input stream_done, output ready);
endinterface

interface mrle_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mrle_pkg::CFG_IDX_W-1:0]     index;
	logic [mrle_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/mrle_cfg.sv
// ----------------------------------------------------------------------------
// mrle_cfg
// Configuration register file with write strobes for the loaded counters.
// ----------------------------------------------------------------------------
module mrle_cfg (
	input  logic               clk,
	input  logic               arst_n,
	mrle_cfg_if.sink           cfg_ch,
	output mrle_pkg::cfg_t     cfg
);

	logic       wr;
	logic       framed_mode_q;
	logic [7:0] single_marker_q;

	assign cfg_ch.ready = 1'b1;
	assign wr = cfg_ch.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framed_mode_q <= 1'b1;
			single_marker_q <= 8'd0;
		end else if (wr) begin
			if (cfg_ch.index == mrle_pkg::REG_FRAMED_MODE) begin
				framed_mode_q <= cfg_ch.data[0];
			end
			if (cfg_ch.index == mrle_pkg::REG_SINGLE_MARKER) begin
				single_marker_q <= cfg_ch.data[7:0];
			end
		end
	end

	always_comb begin
		cfg.framed_mode = framed_mode_q;
		cfg.single_marker = single_marker_q;
		cfg.block_count_wr = wr && (cfg_ch.index == mrle_pkg::REG_BLOCK_COUNT);
		cfg.output_limit_wr = wr && (cfg_ch.index == mrle_pkg::REG_OUTPUT_LIMIT);
		cfg.wr_data = cfg_ch.data;
	end

endmodule

### sv/mrle_in_reg.sv
// ----------------------------------------------------------------------------
// mrle_in_reg
// Input register stage holding one accepted compressed byte.
// ----------------------------------------------------------------------------
module mrle_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	mrle_in_if.sink              in_ch,
	input  logic                 advance,
	output logic                 valid_s1,
	output mrle_pkg::in_item_t   item_s1
);

	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.last_byte <= in_ch.last_byte;
		end
	end

endmodule

### sv/mrle_core.sv
// ----------------------------------------------------------------------------
// mrle_core
// Block header parser, escape decoder and output limit tracking.
// ----------------------------------------------------------------------------
module mrle_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrle_pkg::cfg_t       cfg,
	input  logic                 fire,
	input  mrle_pkg::in_item_t   item_s1,
	output logic                 res_valid,
	output mrle_pkg::result_t    res
);

	localparam logic [2:0] PH_HDR = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_ESCN = 3'd2;
	localparam logic [2:0] PH_ESCLO = 3'd3;
	localparam logic [2:0] PH_ESCHI = 3'd4;
	localparam logic [2:0] PH_ESCV = 3'd5;
	localparam logic [2:0] PH_PASS = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  hidx_q, hidx_d;
	logic [15:0] bbl_q, bbl_d;
	logic [15:0] blocks_q, blocks_d;
	logic [7:0]  marker_q, marker_d;
	logic [15:0] plen_q, plen_d;
	logic [31:0] room_q, room_d;
	logic [31:0] emitted_q, emitted_d;

	logic        run_req;
	logic [7:0]  run_v;
	logic [15:0] run_n;
	logic [15:0] take;
	logic        body;
	logic        endb;
	logic        have;
	logic        mal;
	logic        done;
	logic [7:0]  b;

	assign b = item_s1.data_byte;

	always_comb begin
		phase_d = phase_q;
		hidx_d = hidx_q;
		bbl_d = bbl_q;
		blocks_d = blocks_q;
		marker_d = marker_q;
		plen_d = plen_q;
		room_d = room_q;
		emitted_d = emitted_q;
		run_req = 1'b0;
		run_v = 8'd0;
		run_n = 16'd0;
		take = 16'd0;
		body = 1'b0;
		endb = 1'b0;
		have = 1'b0;
		mal = 1'b0;
		done = 1'b0;
		if (fire && phase_q != PH_DONE) begin
			if (phase_d == PH_HDR && hidx_d == 3'd0 && !cfg.framed_mode) begin
				marker_d = cfg.single_marker;
				blocks_d = 16'd0;
				phase_d = PH_BODY;
			end else if (phase_d == PH_HDR && hidx_d == 3'd0 && blocks_d == 16'd0) begin
				phase_d = PH_PASS;
			end
			unique case (phase_d)
				PH_HDR: begin
					if (hidx_d == 3'd0) begin
						bbl_d = {8'd0, b};
					end else if (hidx_d == 3'd1) begin
						bbl_d = {b, bbl_d[7:0]};
					end
					if (hidx_d >= 3'd4) begin
						marker_d = b;
						bbl_d = (bbl_d < mrle_pkg::HEADER_BYTES) ? 16'd0
							: bbl_d - mrle_pkg::HEADER_BYTES;
						hidx_d = 3'd0;
						phase_d = PH_BODY;
						endb = (bbl_d == 16'd0);
					end else begin
						hidx_d = hidx_d + 3'd1;
					end
				end
				PH_PASS: begin
					run_req = 1'b1;
					run_v = b;
					run_n = 16'd1;
				end
				PH_BODY: begin
					body = 1'b1;
					if (b == marker_d) begin
						phase_d = PH_ESCN;
					end else begin
						run_req = 1'b1;
						run_v = b;
						run_n = 16'd1;
					end
				end
				PH_ESCN: begin
					body = 1'b1;
					if (b != 8'd0) begin
						plen_d = {8'd0, b};
						phase_d = PH_ESCV;
					end else begin
						phase_d = PH_ESCLO;
					end
				end
				PH_ESCLO: begin
					body = 1'b1;
					plen_d = {8'd0, b};
					phase_d = PH_ESCHI;
				end
				PH_ESCHI: begin
					body = 1'b1;
					plen_d = {b, plen_d[7:0]};
					phase_d = PH_ESCV;
				end
				PH_ESCV: begin
					body = 1'b1;
					run_req = 1'b1;
					run_v = b;
					run_n = plen_d;
					phase_d = PH_BODY;
				end
				default: begin
				end
			endcase

			if (run_req && run_n != 16'd0) begin
				have = 1'b1;
				take = (room_q < {16'd0, run_n}) ? room_q[15:0] : run_n;
				room_d = room_q - {16'd0, take};
				emitted_d = emitted_q + {16'd0, take};
			end

			if (body && blocks_d != 16'd0) begin
				bbl_d = bbl_d - 16'd1;
				if (bbl_d == 16'd0) begin
					if (phase_d != PH_BODY) begin
						mal = 1'b1;
						phase_d = PH_BODY;
					end
					endb = 1'b1;
				end
			end

			if (endb) begin
				blocks_d = blocks_d - 16'd1;
				hidx_d = 3'd0;
				if (blocks_d == 16'd0) begin
					phase_d = PH_DONE;
					done = 1'b1;
				end else begin
					phase_d = PH_HDR;
				end
			end

			if (item_s1.last_byte && phase_d != PH_DONE) begin
				if (phase_d >= PH_ESCN && phase_d <= PH_ESCV) begin
					mal = 1'b1;
				end
				phase_d = PH_DONE;
				done = 1'b1;
			end
		end
		if (cfg.block_count_wr) begin
			blocks_d = cfg.wr_data[15:0];
		end
		if (cfg.output_limit_wr) begin
			room_d = (cfg.wr_data > emitted_q) ? cfg.wr_data - emitted_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			hidx_q <= 3'd0;
			bbl_q <= 16'd0;
			blocks_q <= 16'd0;
			marker_q <= 8'd0;
			plen_q <= 16'd0;
			room_q <= mrle_pkg::OUTPUT_LIMIT_RESET;
			emitted_q <= 32'd0;
		end else begin
			phase_q <= phase_d;
			hidx_q <= hidx_d;
			bbl_q <= bbl_d;
			blocks_q <= blocks_d;
			marker_q <= marker_d;
			plen_q <= plen_d;
			room_q <= room_d;
			emitted_q <= emitted_d;
		end
	end

	always_comb begin
		res_valid = have || mal || done;
		res.out_value = have ? run_v : 8'd0;
		res.out_count = take;
		res.clipped = have && (take != run_n);
		res.malformed = mal;
		res.stream_done = done;
	end

endmodule

### sv/mrle_out_reg.sv
// ----------------------------------------------------------------------------
// mrle_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module mrle_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  mrle_pkg::result_t    res,
	output logic                 can_take,
	mrle_out_if.source           out_ch
);

	logic              valid_s2;
	mrle_pkg::result_t res_s2;

	assign can_take = !valid_s2 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_take) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		out_ch.valid = valid_s2;
		out_ch.out_value = res_s2.out_value;
		out_ch.out_count = res_s2.out_count;
		out_ch.clipped = res_s2.clipped;
		out_ch.malformed = res_s2.malformed;
		out_ch.stream_done = res_s2.stream_done;
	end

endmodule

### sv/marker_rle_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// marker_rle_block_decoder_unit
// Marker byte run-length decoder for framed or single block streams.
// ----------------------------------------------------------------------------
// Compressed bytes enter on in_ch, one item per byte with last_byte marking
// the end of the stream. Each run, literal or flag event leaves on out_ch as
// one item holding the byte value, its repeat count after clipping and the
// clipped, malformed and stream_done flags. Header bytes, escape bytes and
// bytes after the end of the stream give no item.
// Registers are written through cfg_ch, which is always ready; write them
// only while no item is in flight.
// A byte is held in an input register and decoded once the output register
// can take a result; the result is then placed in the output register and
// offered on out_ch. One byte is taken every cycle while out_ch is not
// stalled; the decoder state for each byte is computed combinationally and
// registered as its result is loaded, which sets that rate.
// While the receiver stalls with a result waiting, one further byte is held
// and then in_ch.ready drops. Reset empties both registers and restarts the
// decoder at the first header byte with the register reset values.
// ----------------------------------------------------------------------------
`include "marker_rle_block_decoder_unit_defines.svh"

module marker_rle_block_decoder_unit (
	input  logic         clk,
	input  logic         arst_n,
	mrle_in_if.sink      in_ch,
	mrle_out_if.source   out_ch,
	mrle_cfg_if.sink     cfg_ch
);

	mrle_pkg::cfg_t     cfg;
	mrle_pkg::in_item_t item_s1;
	mrle_pkg::result_t  res;
	logic               valid_s1;
	logic               can_take;
	logic               fire;
	logic               res_valid;

	assign fire = valid_s1 && can_take;

	mrle_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	mrle_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (can_take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mrle_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mrle_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire && res_valid),
		.res      (res),
		.can_take (can_take),
		.out_ch   (out_ch)
	);

	`MRLE_ASSERT_IMPL(a_empty_run_flagged,
		out_ch.valid && out_ch.out_count == 16'd0 && !out_ch.clipped,
		out_ch.malformed || out_ch.stream_done, "Result with zero count carries no flag")
	`MRLE_ASSERT_NEXT(a_silent_after_done,
		out_ch.valid && out_ch.ready && out_ch.stream_done,
		!out_ch.valid, "Result delivered after the end of the stream")
	`MRLE_ASSERT_IMPL(a_stall_blocks_input,
		out_ch.valid && !out_ch.ready && valid_s1,
		!in_ch.ready, "Input accepted while both stages are held")

endmodule
